FILE: src/lsbsc_pkg.sv
// Shared constants, codes and types of the LSB steganography codec.
package lsbsc_pkg;

  localparam int unsigned MaxMessage = 8192;
  localparam int unsigned IdxW       = $clog2(MaxMessage);
  localparam int unsigned CountW     = $clog2(MaxMessage + 1);
  localparam int unsigned TotalW     = CountW + 3;
  localparam int unsigned HeaderBits = 32;
  // Enough for a header plus the largest message a 31-bit length can announce.
  localparam int unsigned BitPosW    = 35;
  localparam int unsigned AddrW      = 4;

  localparam logic [7:0]  SampleMask       = 8'hFE;
  localparam logic [2:0]  ChannelsReset    = 3'd3;
  localparam logic [2:0]  ChannelsMin      = 3'd3;
  localparam logic [2:0]  ChannelsAlpha    = 3'd4;
  localparam logic [1:0]  AlphaPhase       = 2'd3;
  localparam logic [30:0] LengthLimitReset = 31'd10000;

  typedef enum logic [1:0] {
    RegMode     = 2'd0,
    RegChannels = 2'd1,
    RegLimit    = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    CmdStart  = 2'd0,
    CmdAppend = 2'd1,
    CmdImage  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    StPass    = 3'd0,
    StUsed    = 3'd1,
    StInvalid = 3'd2,
    StFew     = 3'd3,
    StFull    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PhHeader  = 4'b0001,
    PhMessage = 4'b0010,
    PhDone    = 4'b0100,
    PhInvalid = 4'b1000
  } phase_e;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [7:0]      data;
  } store_wr_t;

endpackage

FILE: src/lsbsc_store.sv
// Message byte store with a registered read port and write-to-read forwarding.
module lsbsc_store
  import lsbsc_pkg::*;
(
  input  logic                  clk_i,
  input  store_wr_t             wr_i,
  input  logic      [IdxW-1:0]  rd_addr_i,
  output logic      [7:0]       rd_data_o
);

  logic [7:0] mem [MaxMessage];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // A byte written to the entry being watched shows up in the read register at once.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
      rd_data_q <= wr_i.data;
    end else begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/lsb_steganography_codec.sv
// Top level of the LSB steganography codec: control registers, codec state and result register.
//
//   channel   | signals                                  | word
//   ----------+------------------------------------------+----------------------------------
//   input     | in_valid_i / in_ready_o                  | command_i, data_byte_i
//   result    | out_valid_o / out_ready_i                | out_byte_o, byte_ready_o, status_o,
//             |                                          | header_length_o, last_o
//   config    | psel, penable, pwrite, paddr, pwdata     | mode, channel_count, length_limit
//
// One word is taken per cycle unless a stalled result holds it off; its result is registered.
// The message store read register always holds the byte that the current bit position points
// at, so embedding never waits on the memory port.
// A stalled result register holds the input off; it frees itself in the cycle it is taken.
// Reset clears the counters, presets the control registers and leaves the store undefined.
module lsb_steganography_codec
  import lsbsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic        [1:0]  command_i,
  input  logic        [7:0]  data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [7:0]  out_byte_o,
  output logic               byte_ready_o,
  output logic        [2:0]  status_o,
  output logic signed [31:0] header_length_o,
  output logic               last_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Control registers.
  logic        mode_q;
  logic [2:0]  channels_q;
  logic [30:0] limit_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      channels_q <= ChannelsReset;
      limit_q    <= LengthLimitReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegMode:     mode_q     <= pwdata[0];
        RegChannels: channels_q <= pwdata[2:0];
        RegLimit:    limit_q    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegMode:     prdata = {31'd0, mode_q};
      RegChannels: prdata = {29'd0, channels_q};
      RegLimit:    prdata = {1'b0, limit_q};
      default:     prdata = 32'd0;
    endcase
  end

  // Codec state.
  logic [CountW-1:0]  loaded_q, loaded_d;
  logic [BitPosW-1:0] bitpos_q, bitpos_d;
  logic [1:0]         chph_q, chph_d;
  logic [31:0]        len_q, len_d;
  logic [7:0]         acc_q, acc_d;
  phase_e             phase_q, phase_d;

  // Result register.
  logic               out_valid_q;
  logic [7:0]         ob_q, ob_d;
  logic               rdy_q, rdy_d;
  status_e            st_q, st_d;
  logic [31:0]        hl_q, hl_d;
  logic               last_q, last_d;

  logic               in_fire;
  store_wr_t          wr;
  logic [IdxW-1:0]    rd_addr;
  logic [7:0]         rd_byte;

  logic               alpha;
  logic [TotalW-1:0]  total;
  logic [BitPosW-1:0] bitpos_inc;
  logic [31:0]        hdr_word;
  logic               embed_bit;
  logic [31:0]        len_new;
  logic [7:0]         acc_new;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign alpha      = (channels_q == ChannelsAlpha) && (chph_q == AlphaPhase);
  assign total      = TotalW'(HeaderBits) + {loaded_q, 3'b000};
  assign bitpos_inc = bitpos_q + 1'b1;
  assign hdr_word   = 32'(loaded_q);
  // Header bits come from the loaded count; message bits from the watched store byte.
  assign embed_bit  = (bitpos_q < BitPosW'(HeaderBits)) ? hdr_word[bitpos_q[4:0]]
                                                        : rd_byte[bitpos_q[2:0]];
  assign len_new    = len_q | (32'(data_byte_i[0]) << bitpos_q[4:0]);
  assign acc_new    = acc_q | (8'(data_byte_i[0]) << bitpos_q[2:0]);

  always_comb begin
    loaded_d = loaded_q;
    bitpos_d = bitpos_q;
    chph_d   = chph_q;
    len_d    = len_q;
    acc_d    = acc_q;
    phase_d  = phase_q;
    ob_d     = 8'd0;
    rdy_d    = 1'b0;
    st_d     = StPass;
    last_d   = 1'b0;
    hl_d     = mode_q ? len_q : 32'(loaded_q);
    wr.en    = 1'b0;
    wr.addr  = loaded_q[IdxW-1:0];
    wr.data  = data_byte_i;

    if (in_fire) begin
      unique case (command_i)
        CmdStart: begin
          loaded_d = '0;
          bitpos_d = '0;
          chph_d   = '0;
          len_d    = '0;
          acc_d    = '0;
          phase_d  = PhHeader;
          hl_d     = '0;
        end
        CmdAppend: begin
          // Appends are only taken before any sample of the image has moved the bit position or phase.
          if (bitpos_q == '0 && chph_q == '0) begin
            if (loaded_q < CountW'(MaxMessage)) begin
              wr.en    = 1'b1;
              loaded_d = loaded_q + 1'b1;
            end else begin
              st_d = StFull;
            end
          end
          hl_d = 32'(loaded_d);
        end
        CmdImage: begin
          if (!mode_q) begin
            ob_d = data_byte_i;
            if (channels_q < ChannelsMin) begin
              st_d = StFew;
            end else begin
              chph_d = chph_q + 1'b1;
              if (!alpha && (bitpos_q < BitPosW'(total))) begin
                ob_d     = (data_byte_i & SampleMask) | 8'(embed_bit);
                st_d     = StUsed;
                last_d   = (bitpos_inc == BitPosW'(total));
                bitpos_d = bitpos_inc;
              end
            end
            hl_d = 32'(loaded_q);
          end else begin
            chph_d = chph_q + 1'b1;
            priority if (phase_q == PhInvalid) begin
              st_d = StInvalid;
            end else if (!alpha && phase_q == PhHeader) begin
              len_d    = len_new;
              bitpos_d = bitpos_inc;
              st_d     = StUsed;
              if (|bitpos_inc[BitPosW-1:5]) begin
                if (len_new[31] || len_new == 32'd0 || len_new[30:0] > limit_q) begin
                  phase_d = PhInvalid;
                  st_d    = StInvalid;
                end else begin
                  phase_d = PhMessage;
                end
              end
            end else if (!alpha && phase_q == PhMessage) begin
              acc_d    = acc_new;
              bitpos_d = bitpos_inc;
              st_d     = StUsed;
              if (bitpos_q[2:0] == 3'd7) begin
                ob_d  = acc_new;
                rdy_d = 1'b1;
                acc_d = 8'd0;
                // Bytes done after this one equal (bitpos - 32) / 8 + 1.
                if ((bitpos_q[BitPosW-1:3] - 32'd3) == len_q) begin
                  last_d  = 1'b1;
                  phase_d = PhDone;
                end
              end
            end else begin
              st_d = StPass;
            end
            hl_d = len_d;
          end
        end
        default: ;
      endcase
    end
  end

  // Byte index of the next message bit; meaningful once the header is past.
  assign rd_addr = bitpos_d[IdxW+2:3] - IdxW'(HeaderBits / 8);

  lsbsc_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      bitpos_q    <= '0;
      chph_q      <= '0;
      len_q       <= '0;
      acc_q       <= '0;
      phase_q     <= PhHeader;
      out_valid_q <= 1'b0;
    end else begin
      loaded_q <= loaded_d;
      bitpos_q <= bitpos_d;
      chph_q   <= chph_d;
      len_q    <= len_d;
      acc_q    <= acc_d;
      phase_q  <= phase_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ob_q   <= ob_d;
      rdy_q  <= rdy_d;
      st_q   <= st_d;
      hl_q   <= hl_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = ob_q;
  assign byte_ready_o    = rdy_q;
  assign status_o        = st_q;
  assign header_length_o = signed'(hl_q);
  assign last_o          = last_q;

  a_fire_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted word produced no result");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && command_i == CmdStart) |=> (loaded_q == '0 && bitpos_q == '0))
    else $error("start command did not clear progress");

  a_ready_is_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (byte_ready_o || last_o)) |-> (status_o == StUsed))
    else $error("completed byte or last mark without a used bit");

  a_append_only_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (bitpos_q == '0 && chph_q == '0 && command_i == CmdAppend))
    else $error("store written after image samples arrived");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the LSB steganography codec: random traffic, scoreboard, watchdog.
module tb;
  import lsbsc_pkg::*;

  localparam logic [1:0] CmdUnused  = 2'd3;
  localparam int         StuckLimit = 4000;

  typedef enum int {RxFree, RxCoin, RxSparse, RxPeriodic} rx_style_e;

  // Tracks the codec state and holds the result words still owed by the block.
  class codec_scoreboard;
    typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_ready;
      logic [2:0]  status;
      logic [31:0] header_length;
      logic        last;
    } codec_result_t;

    codec_result_t     due_results[$];
    int                fails;
    logic [7:0]        store [MaxMessage];
    logic [31:0]       loaded;
    longint unsigned   bitpos;
    logic [1:0]        chan_phase;
    logic [31:0]       len_acc;
    logic [7:0]        byte_acc;
    phase_e            phase;
    logic              mode;
    logic [2:0]        channels;
    logic [30:0]       limit;

    function new();
      foreach (store[i]) store[i] = 8'h00;
      fails    = 0;
      loaded   = '0;
      mode     = 1'b0;
      channels = ChannelsReset;
      limit    = LengthLimitReset;
      clear_progress();
    endfunction

    function void clear_progress();
      bitpos     = 0;
      chan_phase = '0;
      len_acc    = '0;
      byte_acc   = '0;
      phase      = PhHeader;
    endfunction

    function void set_config(reg_idx_e idx, logic [31:0] value);
      case (idx)
        RegMode:     mode     = value[0];
        RegChannels: channels = value[2:0];
        RegLimit:    limit    = value[30:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Works out the result word caused by one accepted input word.
    function void take_word(logic [1:0] cmd, logic [7:0] data);
      codec_result_t   r;
      logic            alpha;
      logic            bit_v;
      longint unsigned total;
      longint unsigned m;
      logic [7:0]      msg;
      r = '0;
      r.header_length = mode ? len_acc : loaded;
      case (cmd)
        CmdStart: begin
          loaded = '0;
          clear_progress();
          r.header_length = '0;
        end
        CmdAppend: begin
          // Once any sample of this image has moved the bit position or phase the message is frozen.
          if (bitpos != 0 || chan_phase != 0) begin
            r.status = StPass;
          end else if (loaded < MaxMessage) begin
            store[loaded[IdxW-1:0]] = data;
            loaded = loaded + 1;
          end else begin
            r.status = StFull;
          end
          r.header_length = loaded;
        end
        CmdImage: begin
          alpha = (channels == ChannelsAlpha) && (chan_phase == AlphaPhase);
          if (!mode) begin
            r.out_byte = data;
            if (channels < ChannelsMin) begin
              r.status = StFew;
            end else begin
              chan_phase = chan_phase + 2'd1;
              if (!alpha) begin
                total = HeaderBits + 64'(loaded) * 8;
                if (bitpos < total) begin
                  if (bitpos < HeaderBits) begin
                    bit_v = loaded[bitpos[4:0]];
                  end else begin
                    m     = bitpos - HeaderBits;
                    msg   = store[m[IdxW+2:3]];
                    bit_v = msg[m[2:0]];
                  end
                  r.out_byte = (data & SampleMask) | {7'd0, bit_v};
                  r.status   = StUsed;
                  r.last     = (bitpos + 1 == total);
                  bitpos     = bitpos + 1;
                end
              end
            end
            r.header_length = loaded;
          end else begin
            chan_phase = chan_phase + 2'd1;
            if (phase == PhInvalid) begin
              r.status = StInvalid;
            end else if (!alpha && phase == PhHeader) begin
              len_acc  = len_acc | (32'(data[0]) << bitpos[4:0]);
              bitpos   = bitpos + 1;
              r.status = StUsed;
              if (bitpos >= HeaderBits) begin
                if (len_acc[31] || len_acc == 0 || len_acc > {1'b0, limit}) begin
                  phase    = PhInvalid;
                  r.status = StInvalid;
                end else begin
                  phase = PhMessage;
                end
              end
            end else if (!alpha && phase == PhMessage) begin
              m        = bitpos - HeaderBits;
              byte_acc = byte_acc | (8'(data[0]) << m[2:0]);
              bitpos   = bitpos + 1;
              r.status = StUsed;
              if (m[2:0] == 3'd7) begin
                r.out_byte   = byte_acc;
                r.byte_ready = 1'b1;
                byte_acc     = '0;
                if ((m >> 3) + 1 == 64'(len_acc)) begin
                  r.last = 1'b1;
                  phase  = PhDone;
                end
              end
            end
            r.header_length = len_acc;
          end
        end
        default: ;
      endcase
      due_results.push_back(r);
    endfunction

    function void check_result(logic [7:0] ob, logic br, logic [2:0] st,
                               logic [31:0] hl, logic lst);
      codec_result_t r;
      if (due_results.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
        return;
      end
      r = due_results.pop_front();
      if (ob !== r.out_byte) begin
        $error("out_byte: expected %0h, got %0h", r.out_byte, ob);
        fails++;
      end
      if (br !== r.byte_ready) begin
        $error("byte_ready: expected %0d, got %0d", r.byte_ready, br);
        fails++;
      end
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        fails++;
      end
      if (hl !== r.header_length) begin
        $error("header_length: expected %h, got %h", r.header_length, hl);
        fails++;
      end
      if (lst !== r.last) begin
        $error("last: expected %0d, got %0d", r.last, lst);
        fails++;
      end
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready_o;
  logic [1:0]         command     = CmdStart;
  logic [7:0]         data_byte   = 8'h00;
  logic               out_valid_o;
  logic               out_ready   = 1'b0;
  logic [7:0]         out_byte_o;
  logic               byte_ready_o;
  logic [2:0]         status_o;
  logic signed [31:0] header_length_o;
  logic               last_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [AddrW-1:0]   paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  codec_scoreboard sb;
  int              stuck_cycles = 0;
  int              burst_left   = 1;
  int              sent_words   = 0;
  int              random_start;
  logic [1:0]      img_phase    = '0;
  logic            cur_mode     = 1'b0;
  logic [2:0]      cur_channels = ChannelsReset;
  logic [30:0]     cur_limit    = LengthLimitReset;
  rx_style_e       rx_style     = RxFree;
  int              rx_left      = 0;
  int              rx_tick      = 0;

  lsb_steganography_codec DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .command_i       (command),
    .data_byte_i     (data_byte),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .out_byte_o      (out_byte_o),
    .byte_ready_o    (byte_ready_o),
    .status_o        (status_o),
    .header_length_o (header_length_o),
    .last_o          (last_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #6 clk_i = ~clk_i;

  // The receiver switches between a few stall styles every so often.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_style = rx_style_e'($urandom_range(0, 3));
      rx_left  = $urandom_range(16, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_style)
      RxFree:   out_ready <= 1'b1;
      RxCoin:   out_ready <= 1'($urandom_range(0, 1));
      RxSparse: out_ready <= ($urandom_range(0, 3) == 0);
      default:  out_ready <= (rx_tick % 5) < 3;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) sb.take_word(command, data_byte);
      if (out_valid_o && out_ready)
        sb.check_result(out_byte_o, byte_ready_o, status_o, header_length_o, last_o);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= StuckLimit) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Holds valid until the word is taken, then maybe closes the burst with a gap.
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] data);
    in_valid  <= 1'b1;
    command   <= cmd;
    data_byte <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_words++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 120)
                                                : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_config(idx, value);
    case (idx)
      RegMode:     cur_mode     = value[0];
      RegChannels: cur_channels = value[2:0];
      RegLimit:    cur_limit    = value[30:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic start_image();
    send_word(CmdStart, pick_byte());
    img_phase = '0;
  endtask

  // Sends one usable sample, preceded by any due alpha byte and at times by a stray word.
  task automatic send_sample(input logic lsb);
    if (cur_channels == ChannelsAlpha && img_phase == AlphaPhase) begin
      send_word(CmdImage, pick_byte());
      img_phase = img_phase + 2'd1;
    end
    if ($urandom_range(0, 19) == 0)
      send_word($urandom_range(0, 1) ? CmdUnused : CmdAppend, pick_byte());
    send_word(CmdImage, (pick_byte() & SampleMask) | {7'd0, lsb});
    img_phase = img_phase + 2'd1;
  endtask

  task automatic flip_mode();
    wait_idle();
    reg_write(RegMode, {31'd0, ~cur_mode});
  endtask

  task automatic configure_image();
    logic [2:0]  ch;
    logic [30:0] lim;
    wait_idle();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ch = 3'd3;
      4, 5, 6:    ch = 3'd4;
      7:          ch = 3'($urandom_range(1, 2));
      8:          ch = 3'($urandom_range(5, 7));
      default:    ch = 3'($urandom_range(1, 7));
    endcase
    case ($urandom_range(0, 5))
      0:       lim = 31'd1;
      1:       lim = 31'h7FFF_FFFF;
      2:       lim = LengthLimitReset;
      3, 4:    lim = 31'($urandom_range(1, 20));
      default: lim = 31'($urandom);
    endcase
    if (lim == 0) lim = 31'd1;
    reg_write(RegMode, {31'd0, 1'($urandom_range(0, 1))});
    reg_write(RegChannels, {29'd0, ch});
    reg_write(RegLimit, {1'b0, lim});
  endtask

  task automatic run_embed();
    int n;
    int need;
    int flip_at;
    start_image();
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) send_word(CmdAppend, pick_byte());
    need = (cur_channels < ChannelsMin) ? $urandom_range(2, 6)
                                        : 32 + 8 * n + $urandom_range(0, 4);
    flip_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, need - 1) : -1;
    for (int i = 0; i < need; i++) begin
      if (i == flip_at) flip_mode();
      send_sample(1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_extract();
    logic [31:0] len;
    int          extra;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: len = (cur_limit < 3) ? {1'b0, cur_limit} : $urandom_range(1, 3);
      4:          len = 32'd0;
      5:          len = 32'h8000_0000 | $urandom;
      6:          len = {1'b0, cur_limit} + 32'd1;
      default:    len = $urandom_range(1, cur_limit);
    endcase
    start_image();
    for (int i = 0; i < 32; i++) send_sample(len[i]);
    extra = (len >= 1 && len <= 3) ? 8 * len + $urandom_range(0, 4) : $urandom_range(1, 6);
    if ($urandom_range(0, 7) == 0) flip_mode();
    for (int i = 0; i < extra; i++) send_sample(1'($urandom_range(0, 1)));
  endtask

  initial begin
    sb = new();
    burst_left = $urandom_range(1, 12);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset configuration, then the refusal cases.
    start_image();
    send_word(CmdAppend, 8'h00);
    send_word(CmdAppend, 8'hFF);
    send_word(CmdUnused, 8'hFF);
    send_word(CmdImage, 8'hFF);
    send_word(CmdImage, 8'h00);
    send_word(CmdImage, 8'h01);
    send_word(CmdAppend, 8'h5A);
    start_image();
    wait_idle();
    reg_write(RegChannels, 32'd1);
    send_word(CmdImage, 8'h00);
    send_word(CmdImage, 8'hFF);
    wait_idle();
    reg_write(RegChannels, 32'd2);
    send_word(CmdImage, 8'hA5);
    start_image();

    // Load a short message and embed its header and every message bit.
    wait_idle();
    reg_write(RegMode, 32'd0);
    reg_write(RegChannels, 32'd3);
    reg_write(RegLimit, {1'b0, LengthLimitReset});
    start_image();
    for (int i = 0; i < 4; i++) send_word(CmdAppend, pick_byte());
    for (int i = 0; i < 68; i++) send_sample(1'($urandom_range(0, 1)));

    random_start = sent_words;
    while (sent_words - random_start < 300) begin
      configure_image();
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < 12; i++) send_word(2'($urandom_range(0, 3)), pick_byte());
      end else if (cur_mode) begin
        run_extract();
      end else begin
        run_embed();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/lsbsc_pkg.sv
src/lsbsc_store.sv
src/lsb_steganography_codec.sv
verif/tb.sv
